[rtl/sebl_pkg.sv]
package sebl_pkg;

    localparam int TAPS          = 17;
    localparam int HALF          = 8;
    localparam int STORE_ROWS    = 16;
    localparam int SLOT_W        = 4;
    localparam int ROW_W         = 12;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_W         = 32;
    localparam int CH_W          = 8;
    localparam int CHANNELS      = 4;
    localparam int SUM_W         = 18;

    // config register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND   = 2'd2;

    localparam int RST_WIDTH  = 64;
    localparam int RST_HEIGHT = 64;
    localparam int RST_BAND   = 8;

    // floor(s / 748) = (s * 717742) >> 29 for every s below 2^18
    localparam logic [19:0] DIV_MUL = 20'd717742;
    localparam int DIV_SH = 29;

    localparam logic [6:0] WEIGHTS [TAPS] = '{
        7'd9, 7'd15, 7'd24, 7'd34, 7'd46, 7'd59, 7'd70, 7'd77, 7'd80,
        7'd77, 7'd70, 7'd59, 7'd46, 7'd34, 7'd24, 7'd15, 7'd9
    };

    typedef logic [TAPS-1:0][PIX_W-1:0] t_taps;
    typedef logic [CHANNELS-1:0][SUM_W-1:0] t_sums;

    function automatic logic [CH_W-1:0] div748(input logic [SUM_W-1:0] s);
        logic [37:0] p;
        p = 38'(s) * 38'(DIV_MUL);
        return p[DIV_SH+CH_W-1:DIV_SH];
    endfunction

endpackage

[rtl/sebl_ram.sv]
module sebl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[rtl/sebl_tapsum.sv]
module sebl_tapsum
    import sebl_pkg::*;
(
    input  t_taps           i_taps,
    input  logic [TAPS-1:0] i_use,
    output t_sums           o_sums
);

    // weighted sum per channel over the taps in use
    always_comb begin
        o_sums = '0;
        for (int n = 0; n < TAPS; n++) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                if (i_use[n]) begin
                    o_sums[ch] = o_sums[ch]
                        + SUM_W'(i_taps[n][CH_W*ch +: CH_W]) * SUM_W'(WEIGHTS[n]);
                end
            end
        end
    end

endmodule

[rtl/separable_edge_blur_argb.sv]
// Result path: the result for a pixel leaves 8*W+8 stepping transactions after that
//   pixel (W = image width), through the stage registers P, Q, R, S and the output register.
// Throughput: one transaction per clock on both streams unless the output stalls; the
//   16 line RAMs are read together once per transaction and at most one is written.
//   The input is held off after each register write while the pixel count settles.
// Reset (synchronous, active low): registers to 64/64/8, counters and tap window to
//   zero, pipeline empty. The line RAMs are not cleared and need no clearing pass.
module separable_edge_blur_argb
    import sebl_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // [31:0] pixel_in
    input  logic                  s_axis_tuser,   // [0] mode (1 = drain tick)
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,   // [31:0] pixel_out
    output logic                  m_axis_tlast,   // last_pixel
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);          // column index
    localparam int WW    = CW + 1;                     // effective width
    localparam int TOT_W = WW + 13;                    // pixels per image
    localparam int VW    = TOT_W + 1;                  // step count
    localparam int CMPW  = ((WW > 13) ? WW : 13) + 2;  // band and mask compares

    // ---------------------------------------------------------------
    // Configuration registers and derived sizes
    // ---------------------------------------------------------------
    logic [10:0]      r_width;
    logic [12:0]      r_height;
    logic [12:0]      r_band;
    logic             cfg_hit;
    logic             r_cfg_wait;
    logic [WW-1:0]    w_eff;
    logic [12:0]      h_eff;
    logic [TOT_W-1:0] r_total;
    logic [VW-1:0]    total_v;
    logic [VW-1:0]    lat;

    always_comb begin
        unique case (i_cfg_idx)
            CFG_WIDTH, CFG_HEIGHT, CFG_BAND: cfg_hit = i_cfg_we;
            default:                         cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'(RST_WIDTH);
            r_height <= 13'(RST_HEIGHT);
            r_band   <= 13'(RST_BAND);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data[10:0];
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_BAND:   r_band   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // clamp width to 1..MAX_WIDTH and height to 1..4096
    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = 13'd1;
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = 13'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    // pixel count is registered and settles in the cycle after a register write; hold the input meanwhile
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOT_W'(RST_WIDTH * RST_HEIGHT);
        end else begin
            r_total <= TOT_W'(w_eff) * TOT_W'(h_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wait <= 1'b0;
        end else begin
            r_cfg_wait <= cfg_hit;
        end
    end

    assign total_v = VW'(r_total);
    assign lat     = VW'({w_eff, 3'b000}) + VW'(HALF);

    // ---------------------------------------------------------------
    // Stage enables: each stage moves when it is empty or the next one moves
    // ---------------------------------------------------------------
    logic r_p_valid, r_q_valid, r_r_valid, r_s_valid, r_o_valid;
    logic en_o, en_s, en_r, en_q, en_p;

    assign en_o = !r_o_valid || m_axis_tready;
    assign en_s = !r_s_valid || en_o;
    assign en_r = !r_r_valid || en_s;
    assign en_q = !r_q_valid || en_r;
    assign en_p = !r_p_valid || en_q;

    assign s_axis_tready = en_p && !r_cfg_wait;

    // ---------------------------------------------------------------
    // Step control: position counters and tap window
    // ---------------------------------------------------------------
    logic [VW-1:0]     r_v;       // steps taken in this image (ignored drain ticks not counted)
    logic [CW-1:0]     r_hc;      // column of the horizontal result due next
    logic [SLOT_W-1:0] r_hslot;   // its row, modulo the store depth
    logic [CW-1:0]     r_ox;      // column of the next output
    logic [ROW_W-1:0]  r_oy;      // row of the next output
    t_taps             r_win;

    logic            s_accept, step, in_image, h_do, o_do, last;
    logic            hfilt, vfilt;
    logic [TAPS-1:0] hmask, vmask;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign in_image = r_v < total_v;
    // a drain tick inside the image does nothing; a pixel past the end acts as a drain
    assign step     = s_accept && !(in_image && s_axis_tuser);
    assign h_do     = (r_v >= VW'(HALF)) && (r_v < total_v + VW'(HALF));
    assign o_do     = (r_v >= lat) && (r_v < total_v + lat);
    assign last     = o_do && (r_v == total_v + lat - VW'(1));

    // copy pixels strictly inside the band on columns, inclusive on rows
    assign hfilt = !((CMPW'(r_band) < CMPW'(r_hc))
                     && (CMPW'(r_hc) + CMPW'(r_band) < CMPW'(w_eff)));
    assign vfilt = !((CMPW'(r_band) <= CMPW'(r_oy))
                     && (CMPW'(r_oy) + CMPW'(r_band) < CMPW'(h_eff)));

    // skip taps that fall off the image
    always_comb begin
        for (int n = 0; n < TAPS; n++) begin
            hmask[n] = (CMPW'(r_hc) + CMPW'(n) >= CMPW'(HALF))
                    && (CMPW'(r_hc) + CMPW'(n) < CMPW'(w_eff) + CMPW'(HALF));
            vmask[n] = (CMPW'(r_oy) + CMPW'(n) >= CMPW'(HALF))
                    && (CMPW'(r_oy) + CMPW'(n) < CMPW'(h_eff) + CMPW'(HALF));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_v     <= '0;
            r_hc    <= '0;
            r_hslot <= '0;
            r_ox    <= '0;
            r_oy    <= '0;
        end else if (step) begin
            if (last) begin
                // final output of the image: restart for the next one
                r_v     <= '0;
                r_hc    <= '0;
                r_hslot <= '0;
                r_ox    <= '0;
                r_oy    <= '0;
            end else begin
                r_v <= r_v + VW'(1);
                if (h_do) begin
                    if ({1'b0, r_hc} == w_eff - WW'(1)) begin
                        r_hc    <= '0;
                        r_hslot <= r_hslot + SLOT_W'(1);
                    end else begin
                        r_hc <= r_hc + CW'(1);
                    end
                end
                if (o_do) begin
                    if ({1'b0, r_ox} == w_eff - WW'(1)) begin
                        r_ox <= '0;
                        r_oy <= r_oy + ROW_W'(1);
                    end else begin
                        r_ox <= r_ox + CW'(1);
                    end
                end
            end
        end
    end

    // advance the window; past the image zeros shift in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (step) begin
            r_win <= {(in_image ? s_axis_tdata : PIX_W'(0)), r_win[TAPS-1:1]};
        end
    end

    // ---------------------------------------------------------------
    // Stage P: step control held; horizontal sum over the window
    // ---------------------------------------------------------------
    logic              r_p_hdo, r_p_hfilt, r_p_odo, r_p_vfilt, r_p_last;
    logic [TAPS-1:0]   r_p_hmask, r_p_vmask;
    logic [CW-1:0]     r_p_hc, r_p_x;
    logic [SLOT_W-1:0] r_p_hslot, r_p_yslot;
    t_sums             hsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en_p) begin
            r_p_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p) begin
            r_p_hdo   <= h_do;
            r_p_hfilt <= hfilt;
            r_p_hmask <= hmask;
            r_p_hc    <= r_hc;
            r_p_hslot <= r_hslot;
            r_p_odo   <= o_do;
            r_p_vfilt <= vfilt;
            r_p_vmask <= vmask;
            r_p_x     <= r_ox;
            r_p_yslot <= r_oy[SLOT_W-1:0];
            r_p_last  <= last;
        end
    end

    sebl_tapsum u_hsum (
        .i_taps (r_win),
        .i_use  (r_p_hmask),
        .o_sums (hsum)
    );

    // ---------------------------------------------------------------
    // Stage Q: divide the horizontal sum; issue the line store reads
    // ---------------------------------------------------------------
    logic              r_q_hdo, r_q_hfilt, r_q_odo, r_q_vfilt, r_q_last;
    logic [TAPS-1:0]   r_q_vmask;
    logic [CW-1:0]     r_q_hc, r_q_x;
    logic [SLOT_W-1:0] r_q_hslot, r_q_yslot;
    t_sums             r_q_hsum;
    logic [PIX_W-1:0]  r_q_hcopy;
    logic [PIX_W-1:0]  fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (en_q) begin
            r_q_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_q) begin
            r_q_hsum  <= hsum;
            r_q_hcopy <= r_win[HALF];
            r_q_hdo   <= r_p_hdo;
            r_q_hfilt <= r_p_hfilt;
            r_q_hc    <= r_p_hc;
            r_q_hslot <= r_p_hslot;
            r_q_odo   <= r_p_odo;
            r_q_vfilt <= r_p_vfilt;
            r_q_vmask <= r_p_vmask;
            r_q_x     <= r_p_x;
            r_q_yslot <= r_p_yslot;
            r_q_last  <= r_p_last;
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            fresh[CH_W*ch +: CH_W] = r_q_hfilt ? div748(r_q_hsum[ch])
                                               : r_q_hcopy[CH_W*ch +: CH_W];
        end
    end

    // ---------------------------------------------------------------
    // Line store: one RAM per row slot, 16 rows of horizontal results.
    // Reads go out as a transaction enters stage R; the write of the item
    // leaving R at the same edge is forwarded past the RAM.
    // ---------------------------------------------------------------
    logic              r_r_hdo, r_r_odo, r_r_vfilt, r_r_last;
    logic [TAPS-1:0]   r_r_vmask;
    logic [CW-1:0]     r_r_hc;
    logic [SLOT_W-1:0] r_r_hslot, r_r_yslot;
    logic [PIX_W-1:0]  r_r_fresh;

    logic                        ram_we, ram_re;
    logic [PIX_W-1:0]            ram_rd [STORE_ROWS];
    logic [STORE_ROWS-1:0]       r_byp;
    logic [PIX_W-1:0]            r_byp_data;

    assign ram_we = r_r_valid && en_s && r_r_hdo;
    assign ram_re = r_q_valid && en_r;

    for (genvar g = 0; g < STORE_ROWS; g++) begin : g_line
        sebl_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we && (r_r_hslot == SLOT_W'(g))),
            .i_waddr (r_r_hc),
            .i_wdata (r_r_fresh),
            .i_re    (ram_re),
            .i_raddr (r_q_x),
            .o_rdata (ram_rd[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            for (int s = 0; s < STORE_ROWS; s++) begin
                r_byp[s] <= ram_we && (r_r_hslot == SLOT_W'(s)) && (r_r_hc == r_q_x);
            end
            r_byp_data <= r_r_fresh;
        end
    end

    // ---------------------------------------------------------------
    // Stage R: vertical sum over 16 stored rows plus the fresh row
    // ---------------------------------------------------------------
    t_taps vtaps;
    t_sums vsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (en_r) begin
            r_r_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_r) begin
            r_r_fresh <= fresh;
            r_r_hdo   <= r_q_hdo;
            r_r_hc    <= r_q_hc;
            r_r_hslot <= r_q_hslot;
            r_r_odo   <= r_q_odo;
            r_r_vfilt <= r_q_vfilt;
            r_r_vmask <= r_q_vmask;
            r_r_yslot <= r_q_yslot;
            r_r_last  <= r_q_last;
        end
    end

    // tap n is row y-8+n; rows y-8 and y+8 share a slot, the latter is still in flight
    always_comb begin
        logic [SLOT_W-1:0] sl;
        sl = '0;
        for (int n = 0; n < TAPS - 1; n++) begin
            sl = r_r_yslot + SLOT_W'(HALF + n);
            vtaps[n] = r_byp[sl] ? r_byp_data : ram_rd[sl];
        end
        vtaps[TAPS-1] = r_r_fresh;
    end

    sebl_tapsum u_vsum (
        .i_taps (vtaps),
        .i_use  (r_r_vmask),
        .o_sums (vsum)
    );

    // ---------------------------------------------------------------
    // Stage S: divide the vertical sum or pass the stored pixel through
    // ---------------------------------------------------------------
    logic             r_s_odo, r_s_vfilt, r_s_last;
    t_sums            r_s_vsum;
    logic [PIX_W-1:0] r_s_vcopy;
    logic [PIX_W-1:0] result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (en_s) begin
            r_s_valid <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s) begin
            r_s_vsum  <= vsum;
            r_s_vcopy <= vtaps[HALF];
            r_s_odo   <= r_r_odo;
            r_s_vfilt <= r_r_vfilt;
            r_s_last  <= r_r_last;
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            result[CH_W*ch +: CH_W] = r_s_vfilt ? div748(r_s_vsum[ch])
                                                : r_s_vcopy[CH_W*ch +: CH_W];
        end
    end

    // ---------------------------------------------------------------
    // Output register: only transactions that carry a result land here
    // ---------------------------------------------------------------
    logic [PIX_W-1:0] r_o_data;
    logic             r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_o) begin
            r_o_valid <= r_s_valid && r_s_odo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_data <= result;
            r_o_last <= r_s_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

endmodule

[tb/sv/separable_edge_blur_argb_checker.sv]
`timescale 1ns / 100ps

module separable_edge_blur_argb_checker
    import sebl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // [31:0] pixel_in
    input  logic                  s_axis_tuser,   // [0] mode
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [PIX_W-1:0]      m_axis_tdata,   // [31:0] pixel_out
    input  logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int WSUM = 748;

    typedef logic [PIX_W-1:0] pix_row_t [TAPS];
    typedef bit use_row_t [TAPS];
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } blur_out_t;

    const int tap_weight [TAPS] = '{9, 15, 24, 34, 46, 59, 70, 77, 80,
                                    77, 70, 59, 46, 34, 24, 15, 9};

    logic [10:0]      cfg_width;
    logic [12:0]      cfg_height;
    logic [12:0]      cfg_band;
    pix_row_t         window;
    logic [PIX_W-1:0] hstore [STORE_ROWS*MAX_WIDTH_DEF];
    int               step_no;
    blur_out_t        expected_px [$];

    assign o_pending = expected_px.size();

    function automatic logic [PIX_W-1:0] weigh_taps(pix_row_t px, use_row_t on);
        int               acc [CHANNELS];
        logic [PIX_W-1:0] res;
        res = '0;
        for (int c = 0; c < CHANNELS; c++) acc[c] = 0;
        for (int n = 0; n < TAPS; n++)
            if (on[n])
                for (int c = 0; c < CHANNELS; c++)
                    acc[c] += int'(px[n][8*c +: 8]) * tap_weight[n];
        for (int c = 0; c < CHANNELS; c++) res[8*c +: 8] = 8'(acc[c] / WSUM);
        return res;
    endfunction

    // Advance the blur by one accepted transaction; queue the output pixel if one leaves.
    task automatic blur_step(input logic mode, input logic [PIX_W-1:0] pix);
        int               w, h, total, lat, band, v, idx, hr, hc, k, x, y, row;
        logic [PIX_W-1:0] fresh, val;
        bit               have_fresh;
        pix_row_t         taps;
        use_row_t         on;
        blur_out_t        r;
        w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cfg_width);
        h = (cfg_height == 0) ? 1 : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height);
        total = w * h;
        lat = HALF * w + HALF;
        band = int'(cfg_band);
        v = step_no;
        have_fresh = 0;
        fresh = '0;
        hr = 0;
        hc = 0;
        if (v < total && mode) return;   // early drain is ignored
        for (int n = 0; n < TAPS - 1; n++) window[n] = window[n+1];
        window[TAPS-1] = (v < total) ? pix : '0;

        // horizontal pass for the pixel HALF steps back
        if (v >= HALF && v - HALF < total) begin
            idx = v - HALF;
            hr = idx / w;
            hc = idx % w;
            if (band < hc && hc < w - band) begin
                fresh = window[HALF];
            end else begin
                for (int n = 0; n < TAPS; n++) on[n] = (hc - HALF + n >= 0) && (hc - HALF + n < w);
                fresh = weigh_taps(window, on);
            end
            have_fresh = 1;
        end

        // vertical pass, reading the store before this step's write
        if (v >= lat && v - lat < total) begin
            k = v - lat;
            x = k % w;
            y = k / w;
            if (band <= y && y < h - band) begin
                val = hstore[(y % STORE_ROWS) * MAX_WIDTH_DEF + x];
            end else begin
                for (int n = 0; n < TAPS; n++) begin
                    row = y - HALF + n;
                    on[n] = row >= 0 && row < h;
                    taps[n] = '0;
                    if (on[n])
                        taps[n] = (n == TAPS - 1) ? (have_fresh ? fresh : '0)
                                  : hstore[(row % STORE_ROWS) * MAX_WIDTH_DEF + x];
                end
                val = weigh_taps(taps, on);
            end
            r.pixel = val;
            r.last = (k == total - 1);
            expected_px.push_back(r);
        end

        if (have_fresh) hstore[(hr % STORE_ROWS) * MAX_WIDTH_DEF + hc] = fresh;
        step_no = v + 1;
        if (v >= lat && v - lat == total - 1) step_no = 0;
    endtask

    always @(posedge i_clk) begin
        blur_out_t e;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            cfg_width <= 11'(RST_WIDTH);
            cfg_height <= 13'(RST_HEIGHT);
            cfg_band <= 13'(RST_BAND);
            step_no = 0;
            for (int n = 0; n < TAPS; n++) window[n] = '0;
            expected_px.delete();
            o_errors <= 0;
        end else begin
            // config writes restart the image; unknown index is ignored
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH: begin
                        cfg_width <= i_cfg_data[10:0];
                        step_no = 0;
                    end
                    CFG_HEIGHT: begin
                        cfg_height <= i_cfg_data;
                        step_no = 0;
                    end
                    CFG_BAND: begin
                        cfg_band <= i_cfg_data;
                        step_no = 0;
                    end
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) blur_step(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_px.size() == 0) begin
                    $error("unexpected output transaction: pixel_out %h", m_axis_tdata);
                    errs++;
                end else begin
                    e = expected_px.pop_front();
                    if (m_axis_tdata !== e.pixel) begin
                        $error("pixel_out: expected %h, actual %h", e.pixel, m_axis_tdata);
                        errs++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $error("last_pixel: expected %0d, actual %0d", e.last, m_axis_tlast);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
        end
    end

endmodule

[tb/sv/separable_edge_blur_argb_tb.sv]
`timescale 1ns / 100ps

module separable_edge_blur_argb_tb;
    import sebl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;   // index outside the register map
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;
    localparam int   SETTLE_CYCLES = 24;   // pipeline latency plus margin
    localparam int   HOLDOFF_CYCLES = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata;   // [31:0] pixel_in
    logic                  s_axis_tuser;   // [0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [PIX_W-1:0]      m_axis_tdata;   // [31:0] pixel_out
    logic                  m_axis_tlast;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    mismatches;
    int                    pending;

    int pixels_sent;
    int items_sent;
    bit calm;        // no idling in the final stretch
    bit holdoff_req; // ask the receiver for one long stall

    separable_edge_blur_argb dut (.*);

    separable_edge_blur_argb_checker chk (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(mismatches), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: ready in runs, stalled in random bursts, plus one long hold-off on request.
    initial begin
        int run;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_req) begin
                holdoff_req = 0;
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                run = $urandom_range(1, 40);
                repeat (run - 1) begin
                    @(posedge i_clk);
                    if (holdoff_req) break;
                end
            end
        end
    end

    // Offer one transaction and hold it until accepted; idle first at random.
    task automatic send_item(input logic mode, input logic [PIX_W-1:0] pix);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= pix;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (mode == MODE_PIXEL) pixels_sent++;
        items_sent++;
    endtask

    // Drop valid and wait until every predicted pixel has left the block.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Push one whole image: pixels with stray drain ticks, then the flush tail.
    task automatic blur_image(input int wr, input int hr, input int br, input bit pause_mid);
        int w, h, total, lat;
        w = (wr == 0) ? 1 : (wr > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : wr;
        h = (hr == 0) ? 1 : (hr > MAX_HEIGHT) ? MAX_HEIGHT : hr;
        total = w * h;
        lat = HALF * w + HALF;
        write_reg(CFG_WIDTH, CFG_DATA_W'(wr));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(hr));
        write_reg(CFG_BAND, CFG_DATA_W'(br));
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 15) == 0) send_item(MODE_DRAIN, $urandom);   // ignored
            send_item(MODE_PIXEL, pick_pixel());
            if (pause_mid && i == total / 2) wait_drained();
        end
        // a pixel past the end of the image acts as a drain tick
        for (int i = 0; i < lat; i++)
            send_item($urandom_range(0, 3) == 0 ? MODE_PIXEL : MODE_DRAIN, $urandom);
        wait_drained();
    endtask

    initial begin
        int w, h, b;
        calm = 0;
        holdoff_req = 0;
        pixels_sent = 0;
        items_sent = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: tiny image, unused index, clamped and extreme settings
        write_reg(CFG_UNUSED, '1);
        blur_image(3, 2, 0, 0);
        blur_image(0, 0, 8191, 0);
        blur_image(9, 20, 4096, 0);

        // images: one long receiver hold-off; a mid-image sender pause in the first and in about one in ten random ones
        holdoff_req = 1;
        blur_image(17, 12, 8, 1);
        while (items_sent < 1000) begin
            if (items_sent > 900) calm = 1;
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            b = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 8191) : $urandom_range(0, 14);
            blur_image(w, h, b, $urandom_range(0, 9) == 0);
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
